FILE: hw/rtl/decimal_column_bit_packer_core_defines.svh
// Assertion macros for the decimal column bit packer.
`ifndef DECIMAL_COLUMN_BIT_PACKER_CORE_DEFINES_SVH
`define DECIMAL_COLUMN_BIT_PACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define DCBP_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define DCBP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCBP_ASSERT(name, clk, rstn, prop, msg)
`define DCBP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/dcbp_pkg.sv
// Types and constants shared by the decimal column bit packer.
`timescale 1ns / 1ps
`default_nettype none

package dcbp_pkg;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_DEF  = 2'd1,
    PH_EXP  = 2'd2,
    PH_PAIR = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LEN_HIGH  = 3'd1,
    ST_DEF_NZ    = 3'd2,
    ST_PAIR_HIGH = 3'd3,
    ST_LEN_LOW   = 3'd4,
    ST_TRUNC     = 3'd5
  } status_e;

  localparam logic [7:0] EXP_EMPTY = 8'h80;
  localparam logic [7:0] LEN_MAX   = 8'd15;
  localparam logic [7:0] LEN_MIN   = 8'd2;
  localparam logic [7:0] PAIR_MAX  = 8'd127;
  localparam logic [3:0] LEN_EMPTY = 4'd2;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] held_length;
    logic [3:0] digits_left;
    logic [6:0] bit_buffer;   // pending bits, right aligned
    logic [2:0] bit_fill;
    logic [13:0] byte_count;
    logic       dropping;
  } row_state_t;

  localparam row_state_t ROW_IDLE = '{
    phase:       PH_LEN,
    held_length: 4'd0,
    digits_left: 4'd0,
    bit_buffer:  7'd0,
    bit_fill:    3'd0,
    byte_count:  14'd0,
    dropping:    1'b0
  };

  typedef struct packed {
    logic [7:0]  packed_byte;
    logic [2:0]  status;
    logic        out_last;
    logic [13:0] packed_count;
  } result_t;

  // Up to three words produced by one input byte, slot 0 first.
  typedef struct packed {
    result_t [2:0] res;
    logic [1:0]    n;
  } bundle_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dcbp_in_if.sv
// Input channel: one unpacked column-area byte per word.
`timescale 1ns / 1ps
`default_nettype none

interface dcbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dcbp_out_if.sv
// Output channel: one packed byte or status word per word.
`timescale 1ns / 1ps
`default_nettype none

interface dcbp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  packed_byte;
  logic [2:0]  status;
  logic        out_last;
  logic [13:0] packed_count;

  modport source (output valid, output packed_byte, output status, output out_last,
                  output packed_count, input ready);
  modport sink   (input valid, input packed_byte, input status, input out_last,
                  input packed_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/decimal_column_bit_packer_core.sv
// Decimal column bit packer top level.
//
// Input channel in_i takes one byte of a row's variable-column area per word,
// with in_last marking the row's final byte. Output channel out_o gives the
// packed bitstream one byte per word, MSB first, followed or replaced by a
// status word on an error; out_last marks the row's final word and
// packed_count then holds the row total.
// A byte passes from the input register through the combinational step into
// the result buffer. A byte yields up to three words; the buffer hands out one
// word per cycle while the receiver is ready, so the block takes one byte per
// cycle while each byte yields at most one word; a byte with more words waits
// in the input register until the buffer's last held word leaves.
// While the receiver stalls, the held words stay put and the input register
// keeps its byte; in_i.ready stays high while that byte yields no words.
// After an error, bytes are taken and dropped up to the next in_last.
// Reset clears the row state, the input valid flag and the result buffer count.
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_column_bit_packer_core_defines.svh"

module decimal_column_bit_packer_core import dcbp_pkg::*; #(
  parameter int unsigned ROW_BYTES_MAX = 8192
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcbp_in_if.sink    in_i,
  dcbp_out_if.source out_o
);

  localparam logic [13:0] CountCap =
      (ROW_BYTES_MAX < 16383) ? 14'(ROW_BYTES_MAX) : 14'h3FFF;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  row_state_t state_q, state_d;
  bundle_t    bundle;
  logic       can_load;
  logic       advance;
  logic       load;

  assign advance  = in_valid_q && ((bundle.n == 2'd0) || can_load);
  assign load     = advance && (bundle.n != 2'd0);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= ROW_IDLE;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.in_last;
    end
  end

  dcbp_step u_step (
    .state_i     (state_q),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .count_cap_i (CountCap),
    .state_o     (state_d),
    .bundle_o    (bundle)
  );

  dcbp_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .bundle_i   (bundle),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

  `DCBP_ASSERT_ALWAYS(a_drop_clean, clk_i, !state_q.dropping || (state_q.phase == PH_LEN && state_q.bit_fill == 3'd0 && state_q.byte_count == 14'd0), "dropping with live row state")
  `DCBP_ASSERT(a_last_has_word, clk_i, rst_ni, (in_valid_q && in_last_q && !state_q.dropping) |-> (bundle.n != 2'd0), "row end without closing word")
  `DCBP_ASSERT(a_row_end_clears, clk_i, rst_ni, (advance && in_last_q) |=> (state_q.phase == PH_LEN && state_q.byte_count == 14'd0 && !state_q.dropping), "row state not cleared")

endmodule

`default_nettype wire

FILE: hw/rtl/dcbp_step.sv
// Per-byte parse and bit-packing logic: next row state and the words of one byte.
`timescale 1ns / 1ps
`default_nettype none

module dcbp_step import dcbp_pkg::*; (
  input  row_state_t  state_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic [13:0] count_cap_i,
  output row_state_t  state_o,
  output bundle_t     bundle_o
);

  function automatic logic [13:0] sat_inc(input logic [13:0] x, input logic [13:0] cap);
    logic [13:0] r;
    r = (x < cap) ? x + 14'd1 : x;
    return r;
  endfunction

  status_e     err;
  row_state_t  nxt;
  logic [3:0]  nbits;
  logic [11:0] vbits;
  logic [7:0]  pair_val;
  logic [18:0] acc;
  logic [4:0]  tot;
  logic [1:0]  nb;
  logic [2:0]  rem;
  logic [7:0]  byte0, byte1, flush;
  logic [6:0]  new_buf;
  logic [13:0] c1, c2, c3, c_nb, c_nb1;
  logic        has_extra;
  result_t     extra;
  result_t [2:0] res;

  // hi * 10 + lo
  assign pair_val = 8'({byte_i[7:4], 3'b000}) + 8'({byte_i[7:4], 1'b0}) + 8'(byte_i[3:0]);

  always_comb begin
    err   = ST_OK;
    nxt   = state_i;
    nbits = 4'd0;
    vbits = 12'd0;
    case (state_i.phase)
      PH_LEN: begin
        if (byte_i > LEN_MAX) begin
          err = ST_LEN_HIGH;
        end else if (byte_i < LEN_MIN) begin
          err = ST_LEN_LOW;
        end else begin
          nxt.held_length = byte_i[3:0];
          nxt.phase       = PH_DEF;
        end
      end
      PH_DEF: begin
        if (byte_i != 8'd0) begin
          err = ST_DEF_NZ;
        end else begin
          nxt.phase = PH_EXP;
        end
      end
      PH_EXP: begin
        if (state_i.held_length == LEN_EMPTY && byte_i == EXP_EMPTY) begin
          nbits     = 4'd4;    // empty column packs to a single zero nibble
          nxt.phase = PH_LEN;
        end else begin
          nbits           = 4'd12;
          vbits           = {state_i.held_length, byte_i};
          nxt.digits_left = state_i.held_length - LEN_EMPTY;
          nxt.phase       = (nxt.digits_left != 4'd0) ? PH_PAIR : PH_LEN;
        end
      end
      PH_PAIR: begin
        if (pair_val > PAIR_MAX) begin
          err = ST_PAIR_HIGH;
        end else begin
          nbits           = 4'd7;
          vbits           = 12'(pair_val[6:0]);
          nxt.digits_left = state_i.digits_left - 4'd1;
          if (nxt.digits_left == 4'd0) begin
            nxt.phase = PH_LEN;
          end
        end
      end
      default: begin
        err = ST_OK;
      end
    endcase
    if (err == ST_OK && last_i && nxt.phase != PH_LEN) begin
      err = ST_TRUNC;
    end
  end

  // Bit accumulator: at most 7 pending plus 12 new bits.
  always_comb begin
    acc     = (19'(state_i.bit_buffer) << nbits) | 19'(vbits);
    tot     = 5'(state_i.bit_fill) + 5'(nbits);
    nb      = tot[4:3];
    rem     = tot[2:0];
    byte0   = 8'(acc >> (tot - 5'd8));
    byte1   = 8'(acc >> (tot - 5'd16));
    new_buf = 7'(acc) & 7'((8'd1 << rem) - 8'd1);
    flush   = 8'(15'(new_buf) << (4'd8 - 4'(rem)));
  end

  always_comb begin
    c1    = sat_inc(state_i.byte_count, count_cap_i);
    c2    = sat_inc(c1, count_cap_i);
    c3    = sat_inc(c2, count_cap_i);
    c_nb  = (nb == 2'd0) ? state_i.byte_count : ((nb == 2'd1) ? c1 : c2);
    c_nb1 = (nb == 2'd0) ? c1 : ((nb == 2'd1) ? c2 : c3);
  end

  always_comb begin
    has_extra = (err != ST_OK) || (last_i && (rem != 3'd0 || nb == 2'd0));
    extra     = '0;
    if (err != ST_OK) begin
      extra.status       = err;
      extra.out_last     = 1'b1;
      extra.packed_count = c_nb;
    end else if (rem != 3'd0) begin
      extra.packed_byte  = flush;
      extra.out_last     = 1'b1;
      extra.packed_count = c_nb1;
    end else begin
      // last byte with nothing to emit: empty closing word
      extra.out_last     = 1'b1;
      extra.packed_count = state_i.byte_count;
    end

    res    = '0;
    res[0] = '{packed_byte: byte0, status: ST_OK, out_last: 1'b0, packed_count: c1};
    res[1] = '{packed_byte: byte1, status: ST_OK, out_last: 1'b0, packed_count: c2};
    if (has_extra) begin
      res[nb] = extra;
    end else if (last_i && nb != 2'd0) begin
      res[nb - 2'd1].out_last = 1'b1;
    end

    bundle_o.res = res;
    bundle_o.n   = nb + 2'(has_extra);
    state_o      = ROW_IDLE;
    if (state_i.dropping) begin
      bundle_o.n        = 2'd0;
      state_o.dropping  = !last_i;
    end else if (err != ST_OK) begin
      state_o.dropping  = !last_i;
    end else if (!last_i) begin
      state_o            = nxt;
      state_o.bit_buffer = new_buf;
      state_o.bit_fill   = rem;
      state_o.byte_count = c_nb;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dcbp_outbuf.sv
// Result buffer: holds a byte's words, handing out one per cycle while ready.
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_column_bit_packer_core_defines.svh"

module dcbp_outbuf import dcbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bundle_t           bundle_i,
  output logic              can_load_o,
  dcbp_out_if.source        out_o
);

  logic [1:0]    cnt_d, cnt_q;
  result_t [2:0] slot_d, slot_q;
  logic          pop;

  assign pop        = out_o.valid && out_o.ready;
  // refill when empty, or when the last held word leaves this cycle
  assign can_load_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (load_i) begin
      cnt_d  = bundle_i.n;
      slot_d = bundle_i.res;
    end else if (pop) begin
      cnt_d     = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.packed_byte  = slot_q[0].packed_byte;
  assign out_o.status       = slot_q[0].status;
  assign out_o.out_last     = slot_q[0].out_last;
  assign out_o.packed_count = slot_q[0].packed_count;

  `DCBP_ASSERT(a_load_when_free, clk_i, rst_ni, load_i |-> ((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop)), "load into busy buffer")
  `DCBP_ASSERT(a_load_nonempty, clk_i, rst_ni, load_i |-> (bundle_i.n != 2'd0), "empty bundle loaded")
  `DCBP_ASSERT(a_pop_shifts, clk_i, rst_ni, (pop && !load_i && cnt_q == 2'd2) |=> (cnt_q == 2'd1), "pop lost count")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the decimal column bit packer core.
`timescale 1ns / 1ps

module testbench;
  import dcbp_pkg::*;

  localparam int unsigned ROW_BYTES_MAX = 8192;
  localparam int unsigned COUNT_CAP = (ROW_BYTES_MAX < 16383) ? ROW_BYTES_MAX : 16383;
  localparam int unsigned RX_HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;  // wait for all expected words before offering
  } area_byte_t;

  typedef enum int {
    ROW_GOOD,
    ROW_BAD_LEN,
    ROW_BAD_DEF,
    ROW_BAD_PAIR,
    ROW_CUT,
    ROW_NOISE
  } row_kind_e;

  logic clk_i;
  logic rst_ni;

  dcbp_in_if  in_if ();
  dcbp_out_if out_if ();

  decimal_column_bit_packer_core #(
    .ROW_BYTES_MAX(ROW_BYTES_MAX)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  area_byte_t  area_bytes[$];
  logic [7:0]  col_bytes[$];
  result_t     expected_words[$];
  int unsigned bytes_total;
  int unsigned bytes_taken;
  int unsigned words_taken;
  int unsigned errors;
  int unsigned send_wait;
  int unsigned recv_wait;
  logic        rx_hold;

  // Packer state as the design should hold it
  phase_e      row_phase;
  logic [3:0]  col_len;
  logic [3:0]  pairs_left;
  int unsigned pend_bits;
  int unsigned pend_fill;
  int unsigned row_count;
  bit          skip_to_last;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- packing prediction

  function automatic void clear_row();
    row_phase  = PH_LEN;
    col_len    = '0;
    pairs_left = '0;
    pend_bits  = 0;
    pend_fill  = 0;
    row_count  = 0;
  endfunction

  function automatic void add_word(logic [7:0] b, status_e st, logic last);
    result_t w;
    w.packed_byte  = b;
    w.status       = st;
    w.out_last     = last;
    w.packed_count = 14'(row_count);
    expected_words.push_back(w);
  endfunction

  function automatic void bump_count();
    if (row_count < COUNT_CAP) row_count++;
  endfunction

  // Append n bits MSB first, emitting every byte that fills
  function automatic void push_bits(int unsigned v, int unsigned n);
    int unsigned acc;
    int unsigned tot;
    acc = (pend_bits << n) | (v & ((1 << n) - 1));
    tot = pend_fill + n;
    while (tot >= 8) begin
      tot -= 8;
      bump_count();
      add_word(8'((acc >> tot) & 8'hFF), ST_OK, 1'b0);
    end
    pend_bits = acc & ((1 << tot) - 1);
    pend_fill = tot;
  endfunction

  function automatic void take_column_byte(logic [7:0] b, logic last);
    status_e     fault;
    int unsigned first;
    int unsigned val;
    fault = ST_OK;
    first = expected_words.size();
    if (skip_to_last) begin
      if (last) begin
        skip_to_last = 1'b0;
        clear_row();
      end
      return;
    end
    case (row_phase)
      PH_LEN: begin
        if (b > LEN_MAX) fault = ST_LEN_HIGH;
        else if (b < LEN_MIN) fault = ST_LEN_LOW;
        else begin
          col_len   = b[3:0];
          row_phase = PH_DEF;
        end
      end
      PH_DEF: begin
        if (b != '0) fault = ST_DEF_NZ;
        else row_phase = PH_EXP;
      end
      PH_EXP: begin
        if (col_len == LEN_EMPTY && b == EXP_EMPTY) begin
          push_bits(0, 4);
          row_phase = PH_LEN;
        end else begin
          push_bits(32'(col_len), 4);
          push_bits(32'(b), 8);
          pairs_left = col_len - 4'd2;
          row_phase  = (pairs_left != '0) ? PH_PAIR : PH_LEN;
        end
      end
      default: begin
        val = 32'(b[7:4]) * 10 + 32'(b[3:0]);
        if (val > PAIR_MAX) fault = ST_PAIR_HIGH;
        else begin
          push_bits(val, 7);
          pairs_left = pairs_left - 4'd1;
          if (pairs_left == '0) row_phase = PH_LEN;
        end
      end
    endcase

    if (fault == ST_OK && last && row_phase != PH_LEN) fault = ST_TRUNC;

    if (fault != ST_OK) begin
      add_word(8'h00, fault, 1'b1);
      clear_row();
      skip_to_last = !last;
      return;
    end

    if (last) begin
      if (pend_fill > 0) begin
        bump_count();
        add_word(8'((pend_bits << (8 - pend_fill)) & 8'hFF), ST_OK, 1'b1);
      end else if (expected_words.size() > first) begin
        expected_words[expected_words.size() - 1].out_last = 1'b1;
      end else begin
        add_word(8'h00, ST_OK, 1'b1);
      end
      clear_row();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void put(logic [7:0] b, logic last, bit drain);
    area_byte_t item;
    item.data  = b;
    item.last  = last;
    item.drain = drain;
    area_bytes.push_back(item);
  endfunction

  function automatic logic [7:0] good_pair();
    int unsigned hi;
    int unsigned lo;
    if ($urandom_range(0, 6) != 0) begin
      hi = $urandom_range(0, 9);
      lo = $urandom_range(0, 9);
    end else begin
      // non-BCD nibbles still pass as long as the value fits in 7 bits
      hi = $urandom_range(0, 12);
      lo = (hi == 12) ? $urandom_range(0, 7) : $urandom_range(0, 15);
    end
    return 8'((hi << 4) | lo);
  endfunction

  function automatic logic [7:0] bad_pair();
    int unsigned hi;
    int unsigned lo;
    hi = $urandom_range(12, 15);
    lo = (hi == 12) ? $urandom_range(8, 15) : $urandom_range(0, 15);
    return 8'((hi << 4) | lo);
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 4) != 0) ? $urandom_range(2, 5) : $urandom_range(6, 15);
  endfunction

  function automatic void make_column(int unsigned len);
    col_bytes.delete();
    col_bytes.push_back(8'(len));
    col_bytes.push_back(8'h00);
    if (len == LEN_EMPTY && $urandom_range(0, 1) != 0) col_bytes.push_back(EXP_EMPTY);
    else col_bytes.push_back(8'($urandom_range(0, 255)));
    for (int i = 2; i < len; i++) col_bytes.push_back(good_pair());
  endfunction

  function automatic void add_row(bit drain_first);
    row_kind_e   kind;
    int unsigned r;
    int unsigned ncol;
    int unsigned p;
    int unsigned junk;
    bit          stop_here;
    r    = $urandom_range(0, 13);
    kind = (r < 5) ? row_kind_e'(r + 1) : ROW_GOOD;
    ncol = $urandom_range(1, 4);
    if (kind == ROW_NOISE) begin
      junk = $urandom_range(1, 6);
      for (int i = 0; i < junk; i++)
        put(8'($urandom_range(0, 255)), i == junk - 1, drain_first && i == 0);
      return;
    end
    for (int c = 0; c < ncol; c++) begin
      make_column(pick_len());
      if (c == ncol - 1 && kind != ROW_GOOD) begin
        case (kind)
          ROW_BAD_LEN: begin
            p = 0;
            col_bytes[0] = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 1))
                                                      : 8'($urandom_range(16, 255));
          end
          ROW_BAD_DEF: begin
            p = 1;
            col_bytes[1] = 8'($urandom_range(1, 255));
          end
          ROW_BAD_PAIR: begin
            if (col_bytes.size() > 3) begin
              p = $urandom_range(3, col_bytes.size() - 1);
              col_bytes[p] = bad_pair();
            end else begin
              p = 1;
              col_bytes[1] = 8'($urandom_range(1, 255));
            end
          end
          default: p = $urandom_range(0, col_bytes.size() - 2);
        endcase
        stop_here = (kind == ROW_CUT) || ($urandom_range(0, 1) != 0);
        for (int i = 0; i <= p; i++)
          put(col_bytes[i], stop_here && i == p, drain_first && c == 0 && i == 0);
        if (!stop_here) begin
          // bytes the block has to throw away up to the row end
          junk = $urandom_range(0, 3);
          for (int i = 0; i < junk; i++) put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          put(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        return;
      end
      for (int i = 0; i < col_bytes.size(); i++)
        put(col_bytes[i], c == ncol - 1 && i == col_bytes.size() - 1,
            drain_first && c == 0 && i == 0);
    end
  endfunction

  function automatic int unsigned draw_gap(int unsigned seq);
    if ((seq / 40) % 3 == 1) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        take_column_byte(in_if.in_byte, in_if.in_last);
        bytes_taken++;
        send_wait = draw_gap(bytes_taken);
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_if.valid <= 1'b0;
        end else if (area_bytes.size() == 0 ||
                     (area_bytes[0].drain && expected_words.size() != 0)) begin
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= area_bytes[0].data;
          in_if.in_last <= area_bytes[0].last;
          void'(area_bytes.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : rx_side
    result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        words_taken++;
        if (expected_words.size() == 0) begin
          $error("unexpected word: packed_byte %02h status %0d out_last %0b",
                 out_if.packed_byte, out_if.status, out_if.out_last);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (out_if.packed_byte !== want.packed_byte) begin
            $error("packed_byte: expected %02h, got %02h", want.packed_byte, out_if.packed_byte);
            errors++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            errors++;
          end
          if (out_if.out_last !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, out_if.out_last);
            errors++;
          end
          if (out_if.packed_count !== want.packed_count) begin
            $error("packed_count: expected %0d, got %0d",
                   want.packed_count, out_if.packed_count);
            errors++;
          end
        end
        recv_wait = draw_gap(words_taken + 20);
      end
      if (rx_hold) begin
        out_if.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver stall so the block backs up and stalls its input
  initial begin
    rx_hold = 1'b0;
    wait (rst_ni === 1'b1);
    while (words_taken < 40) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned rows;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    bytes_taken   = 0;
    words_taken   = 0;
    errors        = 0;
    send_wait     = 0;
    recv_wait     = 0;
    skip_to_last  = 1'b0;
    clear_row();

    // empty column: a lone 4-bit zero, flushed
    put(8'd2, 1'b0, 1'b1);
    put(8'h00, 1'b0, 1'b0);
    put(EXP_EMPTY, 1'b1, 1'b0);
    // length-12 column with extreme pairs
    put(8'd12, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'h99, 1'b0, 1'b0);
    put(8'hC7, 1'b0, 1'b0);  // 127, largest legal pair
    put(8'h0F, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) put(good_pair(), i == 5, 1'b0);
    // length over 15, then a dropped tail
    put(8'd16, 1'b0, 1'b0);
    put(8'h33, 1'b1, 1'b0);
    // lengths under 2
    put(8'd0, 1'b1, 1'b0);
    put(8'd1, 1'b1, 1'b0);
    // defined byte nonzero
    put(8'd2, 1'b0, 1'b0);
    put(8'h01, 1'b0, 1'b0);
    put(8'hAA, 1'b1, 1'b0);
    // pair just over the limit on the last byte
    put(8'd3, 1'b0, 1'b1);
    put(8'h00, 1'b0, 1'b0);
    put(EXP_EMPTY, 1'b0, 1'b0);
    put(8'hC8, 1'b1, 1'b0);
    // column cut short
    put(8'd3, 1'b0, 1'b0);
    put(8'h00, 1'b1, 1'b0);
    put(8'hFF, 1'b1, 1'b0);

    rows = 0;
    while (area_bytes.size() < 380) begin
      add_row(rows % 12 == 11);
      rows++;
    end
    bytes_total = area_bytes.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (bytes_taken < bytes_total) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/dcbp_pkg.sv
hw/rtl/dcbp_in_if.sv
hw/rtl/dcbp_out_if.sv
hw/rtl/dcbp_step.sv
hw/rtl/dcbp_outbuf.sv
hw/rtl/decimal_column_bit_packer_core.sv
tb/sv/testbench.sv
